### hdl/ptsd_pkg.sv
// types and constants shared by the point to triangle distance pipeline
// depends on nothing
package ptsd_pkg;

    localparam int IN_W      = 16;
    localparam int DIST_BITS = 50;
    localparam int FEAT_W    = 3;

    localparam logic [FEAT_W-1:0] FEAT_VERT0  = 3'd0;
    localparam logic [FEAT_W-1:0] FEAT_VERT1  = 3'd1;
    localparam logic [FEAT_W-1:0] FEAT_VERT2  = 3'd2;
    localparam logic [FEAT_W-1:0] FEAT_EDGE01 = 3'd3;
    localparam logic [FEAT_W-1:0] FEAT_EDGE12 = 3'd4;
    localparam logic [FEAT_W-1:0] FEAT_EDGE20 = 3'd5;
    localparam logic [FEAT_W-1:0] FEAT_FACE   = 3'd6;

    typedef struct packed {
        logic signed [IN_W-1:0] query_x;
        logic signed [IN_W-1:0] query_y;
        logic signed [IN_W-1:0] query_z;
        logic signed [IN_W-1:0] vert0_x;
        logic signed [IN_W-1:0] vert0_y;
        logic signed [IN_W-1:0] vert0_z;
        logic signed [IN_W-1:0] vert1_x;
        logic signed [IN_W-1:0] vert1_y;
        logic signed [IN_W-1:0] vert1_z;
        logic signed [IN_W-1:0] vert2_x;
        logic signed [IN_W-1:0] vert2_y;
        logic signed [IN_W-1:0] vert2_z;
    } in_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] dist_squared;
        logic [FEAT_W-1:0]    closest_feature;
    } out_t;

endpackage

### hdl/point_triangle_squared_distance.sv
// squared distance from a point to a triangle with the closest feature, deep pipeline
// depends on ptsd_pkg
//
//  port group    direction  handshake             payload
//  s_*           in         s_valid / s_ready     in_t  (query point, three vertices)
//  m_*           out        m_valid / m_ready     out_t (dist_squared, closest_feature)
//
// one beat per cycle in and out while m_ready does not stall the pipe; the depth is
// set by the restoring dividers that take one quotient bit per stage
// four arithmetic stages (differences, cross/dot products, second products, operand select),
// then three divider lanes in lockstep, then the ordering and saturation stage
// aresetn is synchronous; it clears the valid bits only
// a stall on m_ready freezes the whole pipe; s_ready stays high while the last stage is empty
module point_triangle_squared_distance
    import ptsd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int CW   = COORD_BITS;
    localparam int RW   = (CW > IN_W) ? CW : IN_W;
    localparam int DFW  = CW + 1;
    localparam int PW   = 2 * CW + 3;
    localparam int SDW  = 2 * CW + 5;
    localparam int LDW  = 2 * PW + 2;
    localparam int DNW  = PW + DFW + 2;
    localparam int NBW  = 2 * DNW;
    localparam int QW   = 2 * CW + 4 + FRAC_BITS;
    localparam int WW   = LDW + QW;
    localparam int XW   = (QW > DIST_BITS) ? QW : DIST_BITS;
    localparam int NST  = QW + 5;

    logic [NST-1:0] vld_reg;
    logic           en;

    assign en      = !vld_reg[NST-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // ---- stage 1: coordinates and edge vectors
    logic signed [IN_W-1:0] raw [4][3];
    logic signed [CW-1:0]   crd [4][3];

    assign raw[0][0] = s_data.query_x;
    assign raw[0][1] = s_data.query_y;
    assign raw[0][2] = s_data.query_z;
    assign raw[1][0] = s_data.vert0_x;
    assign raw[1][1] = s_data.vert0_y;
    assign raw[1][2] = s_data.vert0_z;
    assign raw[2][0] = s_data.vert1_x;
    assign raw[2][1] = s_data.vert1_y;
    assign raw[2][2] = s_data.vert1_z;
    assign raw[3][0] = s_data.vert2_x;
    assign raw[3][1] = s_data.vert2_y;
    assign raw[3][2] = s_data.vert2_z;

    // d_k = q - v_k, e = v1-v0, v2-v1, v0-v2, f = v0-v1, v1-v2, v2-v0
    logic signed [DFW-1:0] d_reg [3][3];
    logic signed [DFW-1:0] e_reg [3][3];
    logic signed [DFW-1:0] f_reg [3][3];
    logic signed [DFW-1:0] d_next [3][3];
    logic signed [DFW-1:0] e_next [3][3];
    logic signed [DFW-1:0] f_next [3][3];

    for (genvar p = 0; p < 4; p++) begin : g_crd
        for (genvar ax = 0; ax < 3; ax++) begin : g_ax
            logic [RW-1:0] ext;
            assign ext         = RW'($unsigned(raw[p][ax]));
            assign crd[p][ax]  = $signed(ext[CW-1:0]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_s1
        localparam int KN = (k + 1) % 3;
        for (genvar ax = 0; ax < 3; ax++) begin : g_ax
            assign d_next[k][ax] = DFW'(crd[0][ax]) - DFW'(crd[k+1][ax]);
            assign e_next[k][ax] = DFW'(crd[KN+1][ax]) - DFW'(crd[k+1][ax]);
            assign f_next[k][ax] = DFW'(crd[k+1][ax]) - DFW'(crd[KN+1][ax]);
        end
    end

    // ---- stage 2: normal, cross products, first dots
    logic signed [PW-1:0]  n_reg  [3];
    logic signed [PW-1:0]  cl_reg [3][3];
    logic signed [PW-1:0]  cs_reg [3][3];
    logic signed [SDW-1:0] sd_reg [3];
    logic signed [SDW-1:0] ln_reg [3];
    logic signed [SDW-1:0] dd_reg [3];
    logic signed [DFW-1:0] d0_reg [3];
    logic signed [PW-1:0]  n_next  [3];
    logic signed [PW-1:0]  cl_next [3][3];
    logic signed [PW-1:0]  cs_next [3][3];
    logic signed [SDW-1:0] sd_next [3];
    logic signed [SDW-1:0] ln_next [3];
    logic signed [SDW-1:0] dd_next [3];

    // normal = (v1-v0) x (v2-v0) = e[0] x f[2]
    for (genvar ax = 0; ax < 3; ax++) begin : g_n
        localparam int A1 = (ax + 1) % 3;
        localparam int A2 = (ax + 2) % 3;
        assign n_next[ax] = PW'(e_reg[0][A1]) * PW'(f_reg[2][A2])
                          - PW'(e_reg[0][A2]) * PW'(f_reg[2][A1]);
    end

    for (genvar k = 0; k < 3; k++) begin : g_s2
        localparam int KS = (k + 1) % 3;
        for (genvar ax = 0; ax < 3; ax++) begin : g_ax
            localparam int A1 = (ax + 1) % 3;
            localparam int A2 = (ax + 2) % 3;
            assign cl_next[k][ax] = PW'(e_reg[k][A1]) * PW'(d_reg[k][A2])
                                  - PW'(e_reg[k][A2]) * PW'(d_reg[k][A1]);
            assign cs_next[k][ax] = PW'(f_reg[k][A1]) * PW'(d_reg[KS][A2])
                                  - PW'(f_reg[k][A2]) * PW'(d_reg[KS][A1]);
        end
        // segment k runs from v_{k+1} to v_k, so its start offset is d_{k+1}
        assign sd_next[k] = SDW'(f_reg[k][0]) * SDW'(d_reg[KS][0])
                          + SDW'(f_reg[k][1]) * SDW'(d_reg[KS][1])
                          + SDW'(f_reg[k][2]) * SDW'(d_reg[KS][2]);
        assign ln_next[k] = SDW'(f_reg[k][0]) * SDW'(f_reg[k][0])
                          + SDW'(f_reg[k][1]) * SDW'(f_reg[k][1])
                          + SDW'(f_reg[k][2]) * SDW'(f_reg[k][2]);
        assign dd_next[k] = SDW'(d_reg[k][0]) * SDW'(d_reg[k][0])
                          + SDW'(d_reg[k][1]) * SDW'(d_reg[k][1])
                          + SDW'(d_reg[k][2]) * SDW'(d_reg[k][2]);
    end

    // ---- stage 3: second level dots
    logic signed [LDW-1:0] lf_reg [3];
    logic signed [LDW-1:0] cc_reg [3];
    logic signed [LDW-1:0] nn_reg;
    logic signed [DNW-1:0] dn_reg;
    logic                  nz_reg;
    logic signed [SDW-1:0] sd3_reg [3];
    logic signed [SDW-1:0] ln3_reg [3];
    logic signed [SDW-1:0] dd3_reg [3];
    logic signed [LDW-1:0] lf_next [3];
    logic signed [LDW-1:0] cc_next [3];
    logic signed [LDW-1:0] nn_next;
    logic signed [DNW-1:0] dn_next;

    for (genvar k = 0; k < 3; k++) begin : g_s3
        assign lf_next[k] = LDW'(cl_reg[k][0]) * LDW'(n_reg[0])
                          + LDW'(cl_reg[k][1]) * LDW'(n_reg[1])
                          + LDW'(cl_reg[k][2]) * LDW'(n_reg[2]);
        assign cc_next[k] = LDW'(cs_reg[k][0]) * LDW'(cs_reg[k][0])
                          + LDW'(cs_reg[k][1]) * LDW'(cs_reg[k][1])
                          + LDW'(cs_reg[k][2]) * LDW'(cs_reg[k][2]);
    end
    assign nn_next = LDW'(n_reg[0]) * LDW'(n_reg[0]) + LDW'(n_reg[1]) * LDW'(n_reg[1])
                   + LDW'(n_reg[2]) * LDW'(n_reg[2]);
    assign dn_next = DNW'(n_reg[0]) * DNW'(d0_reg[0]) + DNW'(n_reg[1]) * DNW'(d0_reg[1])
                   + DNW'(n_reg[2]) * DNW'(d0_reg[2]);

    // ---- stage 4: face test and divider operands
    logic [WW-1:0] rem_reg [QW+1][3];
    logic [LDW-1:0] den_reg [QW+1][3];
    logic [QW-1:0] q_reg   [QW+1][3];
    logic          face_reg [QW+1];
    logic [WW-1:0] num4_next [3];
    logic [LDW-1:0] den4_next [3];
    logic          face_next;
    logic signed [NBW-1:0] dnsq;

    // dn squared from a signed upper half and an unsigned lower half
    localparam int LW  = DNW / 2;
    localparam int HW  = DNW - LW;
    localparam int HHW = 2 * HW;
    localparam int HLW = HW + LW + 1;
    localparam int LLW = 2 * LW;
    logic signed [HW-1:0]  dn_hi;
    logic [LW-1:0]         dn_lo;
    logic signed [HHW-1:0] dn_hh;
    logic signed [HLW-1:0] dn_hl;
    logic [LLW-1:0]        dn_ll;

    assign dn_hi = $signed(dn_reg[DNW-1:LW]);
    assign dn_lo = dn_reg[LW-1:0];
    assign dn_hh = HHW'(dn_hi) * HHW'(dn_hi);
    assign dn_hl = HLW'(dn_hi) * HLW'($signed({1'b0, dn_lo}));
    assign dn_ll = LLW'(dn_lo) * LLW'(dn_lo);
    assign dnsq  = (NBW'(dn_hh) << (2 * LW)) + (NBW'(dn_hl) << (LW + 1)) + NBW'(dn_ll);

    assign face_next = nz_reg && (lf_reg[0] > 0) && (lf_reg[1] > 0) && (lf_reg[2] > 0);

    for (genvar k = 0; k < 3; k++) begin : g_s4
        logic [WW-1:0]  seg_num;
        logic [LDW-1:0] seg_den;
        localparam int KE = k;
        localparam int KS = (k + 1) % 3;
        always_comb begin
            // endpoint cases divide by one
            seg_den = LDW'(1'b1);
            if (sd3_reg[k] <= 0) begin
                seg_num = WW'($unsigned(dd3_reg[KS]));
            end else if (sd3_reg[k] > ln3_reg[k]) begin
                seg_num = WW'($unsigned(dd3_reg[KE]));
            end else begin
                seg_num = WW'($unsigned(cc_reg[k]));
                seg_den = LDW'($unsigned(ln3_reg[k]));
            end
        end
        if (k == 0) begin : g_face
            assign num4_next[k] = (face_next ? WW'($unsigned(dnsq)) : seg_num) << FRAC_BITS;
            assign den4_next[k] = face_next ? $unsigned(nn_reg) : seg_den;
        end else begin : g_seg
            assign num4_next[k] = seg_num << FRAC_BITS;
            assign den4_next[k] = seg_den;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg  <= d_next;
            e_reg  <= e_next;
            f_reg  <= f_next;
            n_reg  <= n_next;
            cl_reg <= cl_next;
            cs_reg <= cs_next;
            sd_reg <= sd_next;
            ln_reg <= ln_next;
            dd_reg <= dd_next;
            d0_reg <= d_reg[0];
            lf_reg <= lf_next;
            cc_reg <= cc_next;
            nn_reg <= nn_next;
            dn_reg <= dn_next;
            nz_reg <= (n_reg[0] != 0) || (n_reg[1] != 0) || (n_reg[2] != 0);
            sd3_reg <= sd_reg;
            ln3_reg <= ln_reg;
            dd3_reg <= dd_reg;
            face_reg[0] <= face_next;
            for (int k = 0; k < 3; k++) begin
                rem_reg[0][k] <= num4_next[k];
                den_reg[0][k] <= den4_next[k];
                q_reg[0][k]   <= '0;
            end
        end
    end

    // ---- restoring dividers, one quotient bit per stage, msb first
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic [WW-1:0] sh;
            logic          ge;
            assign sh = WW'(den_reg[j][k]) << B;
            assign ge = rem_reg[j][k] >= sh;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j+1][k] <= ge ? rem_reg[j][k] - sh : rem_reg[j][k];
                    den_reg[j+1][k] <= den_reg[j][k];
                    q_reg[j+1][k]   <= q_reg[j][k] | (QW'(ge) << B);
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                face_reg[j+1] <= face_reg[j];
            end
        end
    end

    // ---- final stage: order the edges, pick the feature, saturate
    logic [QW-1:0]     ds [3];
    logic [1:0]        first, second;
    logic [QW-1:0]     dmin;
    logic [FEAT_W-1:0] feat;
    logic [XW-1:0]     dx;
    out_t              out_next;
    out_t              out_reg;

    assign ds[0] = q_reg[QW][0];
    assign ds[1] = q_reg[QW][1];
    assign ds[2] = q_reg[QW][2];

    always_comb begin
        first = 2'd0;
        if (ds[1] < ds[0]) first = 2'd1;
        if (ds[2] < ds[first]) first = 2'd2;
        case (first)
            2'd0:    second = (ds[2] < ds[1]) ? 2'd2 : 2'd1;
            2'd1:    second = (ds[2] < ds[0]) ? 2'd2 : 2'd0;
            default: second = (ds[1] < ds[0]) ? 2'd1 : 2'd0;
        endcase
        dmin = ds[first];
        if (face_reg[QW]) begin
            dmin = ds[0];
            feat = FEAT_FACE;
        end else if (ds[first] == ds[second]) begin
            // tie between two edges: report their shared vertex
            if (first != 2'd2 && second != 2'd2) begin
                feat = FEAT_VERT1;
            end else if (first != 2'd1 && second != 2'd1) begin
                feat = FEAT_VERT0;
            end else begin
                feat = FEAT_VERT2;
            end
        end else begin
            case (first)
                2'd0:    feat = FEAT_EDGE01;
                2'd1:    feat = FEAT_EDGE12;
                default: feat = FEAT_EDGE20;
            endcase
        end
        dx = XW'(dmin);
        out_next.closest_feature = feat;
        if ((dx >> DIST_BITS) != '0) begin
            out_next.dist_squared = '1;
        end else begin
            out_next.dist_squared = dx[DIST_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

### hdl/ptsd_checker.sv
// port level checks for the point to triangle distance pipeline, bound to the top level
// depends on ptsd_pkg and point_triangle_squared_distance
module ptsd_checker
    import ptsd_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // reset empties the pipe
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an empty output stage never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // feature codes above the face code never appear
    a_feat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.closest_feature <= FEAT_FACE)
        else $error("bad feature code");

endmodule

bind point_triangle_squared_distance ptsd_checker u_ptsd_checker (.*);

### sim/ptsd_checker.sv
// checker for the point to triangle distance pipeline: watches both channels,
// predicts each result and compares it with what comes out
// depends on ptsd_pkg
module ptsd_scoreboard
    import ptsd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   pending
);

    localparam int FRAC = 16;

    out_t dist_queue[$];

    function automatic logic signed [255:0] seg_dist(
        input logic signed [63:0] q[3], input logic signed [63:0] s[3],
        input logic signed [63:0] e[3]);
        logic signed [63:0] ev[3], sq[3], eq[3], c[3];
        logic signed [63:0] d, len;
        logic signed [255:0] num;
        for (int i = 0; i < 3; i++) begin
            ev[i] = e[i] - s[i];
            sq[i] = q[i] - s[i];
            eq[i] = q[i] - e[i];
        end
        d = ev[0] * sq[0] + ev[1] * sq[1] + ev[2] * sq[2];
        if (d <= 0)
            return (256'(sq[0] * sq[0]) + 256'(sq[1] * sq[1]) + 256'(sq[2] * sq[2])) << FRAC;
        len = ev[0] * ev[0] + ev[1] * ev[1] + ev[2] * ev[2];
        if (d > len)
            return (256'(eq[0] * eq[0]) + 256'(eq[1] * eq[1]) + 256'(eq[2] * eq[2])) << FRAC;
        c[0] = ev[1] * sq[2] - ev[2] * sq[1];
        c[1] = ev[2] * sq[0] - ev[0] * sq[2];
        c[2] = ev[0] * sq[1] - ev[1] * sq[0];
        num = ($signed(256'(c[0])) * c[0] + $signed(256'(c[1])) * c[1]
            + $signed(256'(c[2])) * c[2]) << FRAC;
        return num / $signed(256'(len));
    endfunction

    function automatic logic left_of(
        input logic signed [63:0] q[3], input logic signed [63:0] n[3],
        input logic signed [63:0] s[3], input logic signed [63:0] e[3]);
        logic signed [63:0] ev[3], qv[3], c[3];
        logic signed [255:0] d;
        for (int i = 0; i < 3; i++) begin
            ev[i] = e[i] - s[i];
            qv[i] = q[i] - s[i];
        end
        c[0] = ev[1] * qv[2] - ev[2] * qv[1];
        c[1] = ev[2] * qv[0] - ev[0] * qv[2];
        c[2] = ev[0] * qv[1] - ev[1] * qv[0];
        d = $signed(256'(c[0])) * n[0] + $signed(256'(c[1])) * n[1]
            + $signed(256'(c[2])) * n[2];
        return d > 0;
    endfunction

    function automatic out_t predict_distance(input in_t t);
        logic signed [63:0] q[3], v0[3], v1[3], v2[3], a[3], b[3], n[3];
        logic signed [255:0] ds[3], dmin, dn, nn;
        logic [2:0] feat;
        int first, second;
        out_t r;
        q  = '{t.query_x, t.query_y, t.query_z};
        v0 = '{t.vert0_x, t.vert0_y, t.vert0_z};
        v1 = '{t.vert1_x, t.vert1_y, t.vert1_z};
        v2 = '{t.vert2_x, t.vert2_y, t.vert2_z};
        for (int i = 0; i < 3; i++) begin
            a[i] = v1[i] - v0[i];
            b[i] = v2[i] - v0[i];
        end
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        if ((n[0] != 0 || n[1] != 0 || n[2] != 0) && left_of(q, n, v0, v1)
                && left_of(q, n, v1, v2) && left_of(q, n, v2, v0)) begin
            dn = $signed(256'(n[0])) * (q[0] - v0[0]) + $signed(256'(n[1])) * (q[1] - v0[1])
                + $signed(256'(n[2])) * (q[2] - v0[2]);
            nn = $signed(256'(n[0])) * n[0] + $signed(256'(n[1])) * n[1]
                + $signed(256'(n[2])) * n[2];
            dmin = ((dn * dn) << FRAC) / nn;
            feat = FEAT_FACE;
        end else begin
            ds[0] = seg_dist(q, v1, v0);
            ds[1] = seg_dist(q, v2, v1);
            ds[2] = seg_dist(q, v0, v2);
            first = 0;
            for (int i = 1; i < 3; i++) if (ds[i] < ds[first]) first = i;
            second = -1;
            for (int i = 0; i < 3; i++)
                if (i != first && (second < 0 || ds[i] < ds[second])) second = i;
            dmin = ds[first];
            if (ds[first] == ds[second]) begin
                // two nearest edges tie: report their shared vertex
                if (first + second == 1) feat = FEAT_VERT1;
                else if (first + second == 2) feat = FEAT_VERT0;
                else feat = FEAT_VERT2;
            end else begin
                feat = FEAT_EDGE01 + 3'(first);
            end
        end
        r.dist_squared = (dmin >= (256'(1) << DIST_BITS)) ? '1 : dmin[DIST_BITS-1:0];
        r.closest_feature = feat;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = dist_queue.size();

    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) dist_queue.push_back(predict_distance(s_data));
            if (m_valid && m_ready) begin
                if (dist_queue.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = dist_queue.pop_front();
                    if (m_data.dist_squared !== want.dist_squared)
                        report_mismatch($sformatf("dist_squared got %0d want %0d",
                            m_data.dist_squared, want.dist_squared));
                    if (m_data.closest_feature !== want.closest_feature)
                        report_mismatch($sformatf("closest_feature got %0d want %0d",
                            m_data.closest_feature, want.closest_feature));
                end
            end
        end
    end

endmodule

### sim/tb.sv
// stimulus and verdict for the point to triangle distance pipeline
// depends on ptsd_pkg, ptsd_scoreboard and the block itself
module tb;
    import ptsd_pkg::*;

    localparam int LATENCY   = 57;
    localparam int CYCLE_CAP = 400000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_data;
    int   fail_count;
    int   pending;
    int   cycles = 0;

    always #4 aclk = ~aclk;

    point_triangle_squared_distance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    ptsd_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver stalls in runs of its own, sometimes not at all for a while
    int stall_mode = 0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord(input int span);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    function automatic in_t random_triangle();
        in_t t;
        int span;
        span = $urandom_range(0, 3) == 0 ? 32767 : ($urandom_range(0, 1) ? 20 : 3000);
        t = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
             rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
             rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
        case ($urandom_range(0, 7))
            // flat triangle in z = 0 with the point at a random z over the face or its edge
            0, 1: begin
                t.vert0_z = 0; t.vert1_z = 0; t.vert2_z = 0;
                t.vert0_x = 0; t.vert0_y = 0;
                t.vert1_x = 16'(span); t.vert1_y = 0;
                t.vert2_x = 0; t.vert2_y = 16'(span);
                t.query_x = 16'($urandom_range(0, span / 2));
                t.query_y = 16'($urandom_range(0, span / 2));
            end
            // collinear or repeated vertices
            2: begin
                t.vert2_x = t.vert1_x; t.vert2_y = t.vert1_y; t.vert2_z = t.vert1_z;
            end
            // point on a vertex
            3: begin
                t.query_x = t.vert0_x; t.query_y = t.vert0_y; t.query_z = t.vert0_z;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic send_beat(input in_t t);
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    in_t directed[$];
    in_t t;

    initial begin
        // extremes and special cases
        directed.push_back('0);
        directed.push_back('1);
        directed.push_back({12{16'h7fff}});
        directed.push_back({12{16'h8000}});
        directed.push_back({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                            16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000});
        directed.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                            16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
        // face, ccw and cw
        directed.push_back({16'sd1, 16'sd1, 16'sd5, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        directed.push_back({16'sd1, 16'sd1, -16'sd5, 16'sd0, 16'sd0, 16'sd0,
                            16'sd0, 16'sd10, 16'sd0, 16'sd10, 16'sd0, 16'sd0});
        // near each vertex and edge
        directed.push_back({-16'sd3, -16'sd3, 16'sd1, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        directed.push_back({16'sd13, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        directed.push_back({-16'sd1, 16'sd14, 16'sd2, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        directed.push_back({16'sd5, -16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        directed.push_back({16'sd7, 16'sd7, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        directed.push_back({-16'sd4, 16'sd5, 16'sd3, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        // degenerate: collinear, all one point, zero-length edge
        directed.push_back({16'sd2, 16'sd9, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd4, 16'sd4, 16'sd4, 16'sd8, 16'sd8, 16'sd8});
        directed.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd7, 16'sd7, 16'sd7,
                            16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7});
        directed.push_back({16'sd3, 16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd1, 16'sd0});
        // point on an edge and on the face
        directed.push_back({16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
        directed.push_back({16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_beat(directed[i]);
        s_valid <= 1'b0;

        for (int n = 0; n < 1100; ) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < 1100; k++, n++) begin
                t = random_triangle();
                send_beat(t);
            end
            s_valid <= 1'b0;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge aclk);
            else @(posedge aclk);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/ptsd_pkg.sv
hdl/point_triangle_squared_distance.sv
hdl/ptsd_checker.sv
sim/ptsd_checker.sv
sim/tb.sv
